FILE: rtl/pwl_pkg.sv
// shared constants and codes for the drag area lookup
// no dependencies
package pwl_pkg;

  localparam int DEFAULT_TABLE_DEPTH = 8;

  localparam int WORD_W  = 16;  // table entries, drag area
  localparam int YAW_W   = 17;  // signed q8.8 yaw
  localparam int POWER_W = 12;  // watts
  localparam int APB_AW  = 4;
  localparam int APB_DW  = 32;

  // divider operand widths: |dv| < 2^16, |dy| < 2^17, |span| < 2^16
  localparam int NUM_W = 33;
  localparam int DEN_W = 16;

  localparam logic [WORD_W-1:0] WORD_MAX = '1;

  typedef enum logic [1:0] {
    FUNC_QUERY  = 2'd0,
    FUNC_WR_BP  = 2'd1,
    FUNC_WR_VAL = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    REG_MODE     = 2'd0,
    REG_THRESH   = 2'd1,
    REG_STANDING = 2'd2,
    REG_COUNT    = 2'd3
  } reg_idx_t;

  localparam logic MODE_STEP   = 1'b0;
  localparam logic MODE_INTERP = 1'b1;

  localparam logic [POWER_W-1:0] THRESH_RESET = '1;

endpackage

FILE: rtl/pwl_ram.sv
// generic single write port ram with registered read
// no dependencies
module pwl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/pwl_div.sv
// pipelined restoring divider, one quotient bit per stage, unsigned operands
// no package dependency; sideband tag travels alongside each word
module pwl_div #(
  parameter int NUM_W = 33,
  parameter int DEN_W = 16,
  parameter int TAG_W = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_vld,
  input  logic [NUM_W-1:0] in_num,
  input  logic [DEN_W-1:0] in_den,
  input  logic [TAG_W-1:0] in_tag,
  output logic             out_vld,
  output logic [NUM_W-1:0] out_quo,
  output logic [TAG_W-1:0] out_tag
);

  logic             vld_r [NUM_W];
  logic [DEN_W-1:0] rem_r [NUM_W];
  logic [NUM_W-1:0] num_r [NUM_W];
  logic [DEN_W-1:0] den_r [NUM_W];
  logic [TAG_W-1:0] tag_r [NUM_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < NUM_W; j++) begin
        vld_r[j] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= in_vld;
      for (int j = 1; j < NUM_W; j++) begin
        vld_r[j] <= vld_r[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    logic [DEN_W-1:0] rem_i;
    logic [NUM_W-1:0] num_i;
    logic [DEN_W-1:0] den_i;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             take;
    if (en) begin
      for (int j = 0; j < NUM_W; j++) begin
        if (j == 0) begin
          rem_i    = '0;
          num_i    = in_num;
          den_i    = in_den;
          tag_r[0] <= in_tag;
        end else begin
          rem_i    = rem_r[j-1];
          num_i    = num_r[j-1];
          den_i    = den_r[j-1];
          tag_r[j] <= tag_r[j-1];
        end
        // shift in the next dividend bit, subtract when it fits
        trial = {rem_i, num_i[NUM_W-1]};
        take  = (trial >= {1'b0, den_i});
        diff  = trial - {1'b0, den_i};
        rem_r[j] <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        num_r[j] <= {num_i[NUM_W-2:0], take};
        den_r[j] <= den_i;
      end
    end
  end

  assign out_vld = vld_r[NUM_W-1];
  assign out_quo = num_r[NUM_W-1];
  assign out_tag = tag_r[NUM_W-1];

endmodule

FILE: rtl/pwl_drag_area_lookup.sv
// piecewise linear yaw to drag area lookup, top level
// pipeline: input register, 3 stages, 33 divider stages, output register
// throughput: one word per cycle while the output is not stalled, set by the one-bit-per-stage divider pipeline
// a stalled output freezes the whole pipeline; writes give no result word
// reset: synchronous active low, clears valids, loads config defaults; tables stay unknown
// depends on pwl_pkg, pwl_ram, pwl_div
module pwl_drag_area_lookup #(
  parameter int TABLE_DEPTH = pwl_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_func,
  input  logic [$clog2(TABLE_DEPTH+1)-1:0]    in_entry_index,
  input  logic [pwl_pkg::WORD_W-1:0]          in_entry_word,
  input  logic signed [pwl_pkg::YAW_W-1:0]    in_yaw_angle,
  input  logic [pwl_pkg::POWER_W-1:0]         in_rider_power,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [pwl_pkg::WORD_W-1:0]          out_drag_area,
  output logic                                out_out_of_saddle,
  output logic [$clog2(TABLE_DEPTH+1)-1:0]    out_segment,
  output logic                                out_clipped,
  // apb config port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [pwl_pkg::APB_AW-1:0]          paddr,
  input  logic [pwl_pkg::APB_DW-1:0]          pwdata,
  output logic [pwl_pkg::APB_DW-1:0]          prdata,
  output logic                                pready
);

  import pwl_pkg::*;

  localparam int SEG_W = $clog2(TABLE_DEPTH + 1);
  localparam int BP_AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int RES_W = NUM_W + 2;
  localparam logic [SEG_W-1:0] DEPTH_S = SEG_W'(TABLE_DEPTH);

  // sideband carried through the multiply and divide stages
  typedef struct packed {
    logic              direct;  // result is dval, no interpolation
    logic [WORD_W-1:0] dval;
    logic [WORD_W-1:0] v1;
    logic              oos;
    logic [SEG_W-1:0]  seg;
  } tag_t;

  typedef struct packed {
    logic neg;                  // quotient sign
    tag_t t;
  } div_tag_t;

  localparam int TAG_W = $bits(div_tag_t);

  // global advance: every stage moves when the output word is free or taken
  logic advance;
  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;

  // ---------------------------------------------------------------- config
  logic              mode_r;
  logic [POWER_W-1:0] thresh_r;
  logic [WORD_W-1:0] standing_r;
  logic [SEG_W-1:0]  count_r;
  logic              cfg_wr;
  reg_idx_t          cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_INTERP;
      thresh_r   <= THRESH_RESET;
      standing_r <= '0;
      count_r    <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_MODE:     mode_r     <= pwdata[0];
        REG_THRESH:   thresh_r   <= pwdata[POWER_W-1:0];
        REG_STANDING: standing_r <= pwdata[WORD_W-1:0];
        REG_COUNT:    count_r    <= pwdata[SEG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_MODE:     prdata = APB_DW'(mode_r);
      REG_THRESH:   prdata = APB_DW'(thresh_r);
      REG_STANDING: prdata = APB_DW'(standing_r);
      REG_COUNT:    prdata = APB_DW'(count_r);
      default:      prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- stage 1
  // input register; table writes retire here so they stay ordered with reads
  logic                     s1_vld_r;
  func_t                    s1_func_r;
  logic [SEG_W-1:0]         s1_idx_r;
  logic [WORD_W-1:0]        s1_word_r;
  logic signed [YAW_W-1:0]  s1_yaw_r;
  logic [POWER_W-1:0]       s1_power_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (advance) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_func_r  <= func_t'(in_func);
      s1_idx_r   <= in_entry_index;
      s1_word_r  <= in_entry_word;
      s1_yaw_r   <= in_yaw_angle;
      s1_power_r <= in_rider_power;
    end
  end

  // breakpoint copy in flops for the parallel compare
  logic [WORD_W-1:0] bp_r [TABLE_DEPTH];
  logic              bp_we;
  logic              val_we;
  logic [SEG_W-1:0]  cnt_n;
  logic [SEG_W-1:0]  s_sel;
  logic              beyond;
  logic              query;
  logic              oos;

  assign bp_we  = advance && s1_vld_r && (s1_func_r == FUNC_WR_BP) && (s1_idx_r < DEPTH_S);
  assign val_we = advance && s1_vld_r && (s1_func_r == FUNC_WR_VAL) && (s1_idx_r <= DEPTH_S);
  assign query  = s1_vld_r && (s1_func_r == FUNC_QUERY);
  assign oos    = s1_power_r > thresh_r;

  always_ff @(posedge clk) begin
    if (bp_we) begin
      bp_r[s1_idx_r[BP_AW-1:0]] <= s1_word_r;
    end
  end

  // first breakpoint in use strictly above the yaw, else the count
  always_comb begin
    cnt_n = (count_r > DEPTH_S) ? DEPTH_S : count_r;
    s_sel = cnt_n;
    for (int k = TABLE_DEPTH - 1; k >= 0; k--) begin
      if ((k < int'(cnt_n)) && (s1_yaw_r < $signed({1'b0, bp_r[k]}))) begin
        s_sel = SEG_W'(k);
      end
    end
  end

  assign beyond = (s_sel == cnt_n);

  logic [SEG_W-1:0] v1_addr, v2_addr, s_dec;
  logic [BP_AW-1:0] y1_addr, y2_addr;

  assign s_dec   = s_sel - SEG_W'(1);
  assign v1_addr = s_sel;
  assign v2_addr = beyond ? s_sel : s_sel + SEG_W'(1);
  assign y2_addr = beyond ? '0 : s_sel[BP_AW-1:0];
  assign y1_addr = (s_sel == '0) ? '0 : s_dec[BP_AW-1:0];

  // two read copies of each table, written together
  logic [WORD_W-1:0] v1_rd, v2_rd, y1_rd, y2_rd;

  pwl_ram #(.WIDTH(WORD_W), .DEPTH(TABLE_DEPTH + 1), .AW(SEG_W)) u_val_lo (
    .clk(clk), .we(val_we), .waddr(s1_idx_r), .wdata(s1_word_r),
    .re(advance), .raddr(v1_addr), .rdata(v1_rd)
  );

  pwl_ram #(.WIDTH(WORD_W), .DEPTH(TABLE_DEPTH + 1), .AW(SEG_W)) u_val_hi (
    .clk(clk), .we(val_we), .waddr(s1_idx_r), .wdata(s1_word_r),
    .re(advance), .raddr(v2_addr), .rdata(v2_rd)
  );

  pwl_ram #(.WIDTH(WORD_W), .DEPTH(TABLE_DEPTH), .AW(BP_AW)) u_bp_lo (
    .clk(clk), .we(bp_we), .waddr(s1_idx_r[BP_AW-1:0]), .wdata(s1_word_r),
    .re(advance), .raddr(y1_addr), .rdata(y1_rd)
  );

  pwl_ram #(.WIDTH(WORD_W), .DEPTH(TABLE_DEPTH), .AW(BP_AW)) u_bp_hi (
    .clk(clk), .we(bp_we), .waddr(s1_idx_r[BP_AW-1:0]), .wdata(s1_word_r),
    .re(advance), .raddr(y2_addr), .rdata(y2_rd)
  );

  // ---------------------------------------------------------------- stage 2
  // table words arrive; form the differences
  logic                    s2_vld_r;
  logic                    s2_oos_r;
  logic [SEG_W-1:0]        s2_seg_r;
  logic                    s2_beyond_r;
  logic                    s2_mode_r;
  logic                    s2_szero_r;
  logic signed [YAW_W-1:0] s2_yaw_r;
  logic [WORD_W-1:0]       s2_stand_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (advance) begin
      s2_vld_r <= query;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_oos_r    <= oos;
      s2_seg_r    <= oos ? '0 : s_sel;
      s2_beyond_r <= beyond;
      s2_mode_r   <= mode_r;
      s2_szero_r  <= (s_sel == '0);
      s2_yaw_r    <= s1_yaw_r;
      s2_stand_r  <= standing_r;
    end
  end

  logic [WORD_W-1:0]         y1e;
  logic signed [WORD_W:0]    dv;
  logic signed [WORD_W:0]    span;
  logic signed [YAW_W:0]     dy;
  tag_t                      s2_tag;

  assign y1e  = s2_szero_r ? '0 : y1_rd;   // first segment starts at zero yaw
  assign dv   = $signed({1'b0, v2_rd}) - $signed({1'b0, v1_rd});
  assign span = $signed({1'b0, y2_rd}) - $signed({1'b0, y1e});
  assign dy   = $signed({s2_yaw_r[YAW_W-1], s2_yaw_r}) - $signed({2'b00, y1e});

  always_comb begin
    s2_tag.direct = s2_oos_r || s2_beyond_r || (s2_mode_r == MODE_STEP) || (span == '0);
    s2_tag.dval   = s2_oos_r ? s2_stand_r : v1_rd;
    s2_tag.v1     = v1_rd;
    s2_tag.oos    = s2_oos_r;
    s2_tag.seg    = s2_seg_r;
  end

  // ---------------------------------------------------------------- stage 3
  // signed product
  logic                   s3_vld_r;
  tag_t                   s3_tag_r;
  logic signed [WORD_W:0] s3_dv_r;
  logic signed [WORD_W:0] s3_span_r;
  logic signed [YAW_W:0]  s3_dy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (advance) begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s3_tag_r  <= s2_tag;
      s3_dv_r   <= dv;
      s3_span_r <= span;
      s3_dy_r   <= dy;
    end
  end

  logic signed [RES_W-1:0] prod;
  assign prod = s3_dv_r * s3_dy_r;

  // ---------------------------------------------------------------- stage 4
  // magnitudes and quotient sign into the divider
  logic                    s4_vld_r;
  tag_t                    s4_tag_r;
  logic signed [RES_W-1:0] s4_prod_r;
  logic signed [WORD_W:0]  s4_span_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else if (advance) begin
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s4_tag_r  <= s3_tag_r;
      s4_prod_r <= prod;
      s4_span_r <= s3_span_r;
    end
  end

  logic [RES_W-1:0]  num_abs;
  logic [WORD_W:0]   den_abs;
  div_tag_t          div_in_tag;

  assign num_abs = s4_prod_r[RES_W-1] ? RES_W'(-s4_prod_r) : RES_W'(s4_prod_r);
  assign den_abs = s4_span_r[WORD_W] ? (WORD_W+1)'(-s4_span_r) : (WORD_W+1)'(s4_span_r);

  always_comb begin
    div_in_tag.neg = s4_prod_r[RES_W-1] ^ s4_span_r[WORD_W];
    div_in_tag.t   = s4_tag_r;
  end

  logic             dv_vld;
  logic [NUM_W-1:0] quo;
  logic [TAG_W-1:0] dv_tag_raw;
  div_tag_t         dv_tag;

  pwl_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .TAG_W(TAG_W)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (advance),
    .in_vld  (s4_vld_r),
    .in_num  (num_abs[NUM_W-1:0]),
    .in_den  (den_abs[DEN_W-1:0]),
    .in_tag  (div_in_tag),
    .out_vld (dv_vld),
    .out_quo (quo),
    .out_tag (dv_tag_raw)
  );

  assign dv_tag = div_tag_t'(dv_tag_raw);

  // ---------------------------------------------------------------- output
  // truncated quotient added with its sign, then saturated to the word range
  logic signed [RES_W-1:0] qx, vx, res;
  logic                    res_lo, res_hi;
  logic [WORD_W-1:0]       area;
  logic                    clip;

  assign qx     = $signed(RES_W'(quo));
  assign vx     = $signed(RES_W'(dv_tag.t.v1));
  assign res    = dv_tag.neg ? (vx - qx) : (vx + qx);
  assign res_lo = res[RES_W-1];
  assign res_hi = !res[RES_W-1] && (res[RES_W-2:WORD_W] != '0);

  always_comb begin
    if (dv_tag.t.direct) begin
      area = dv_tag.t.dval;
      clip = 1'b0;
    end else if (res_lo) begin
      area = '0;
      clip = 1'b1;
    end else if (res_hi) begin
      area = WORD_MAX;
      clip = 1'b1;
    end else begin
      area = res[WORD_W-1:0];
      clip = 1'b0;
    end
  end

  logic              out_valid_r;
  logic [WORD_W-1:0] out_area_r;
  logic              out_oos_r;
  logic [SEG_W-1:0]  out_seg_r;
  logic              out_clip_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_area_r <= area;
      out_oos_r  <= dv_tag.t.oos;
      out_seg_r  <= dv_tag.t.seg;
      out_clip_r <= clip;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_drag_area     = out_area_r;
  assign out_out_of_saddle = out_oos_r;
  assign out_segment       = out_seg_r;
  assign out_clipped       = out_clip_r;

  // ---------------------------------------------------------------- checks
  // standing words carry no segment and are never clipped
  a_oos_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_out_of_saddle |-> (out_segment == '0) && !out_clipped)
    else $error("standing word with segment or clip set");

  // a clipped word sits at one end of the range
  a_clip_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_clipped |-> (out_drag_area == '0) || (out_drag_area == WORD_MAX))
    else $error("clipped word not saturated");

  // the pipeline only stalls behind a waiting result word
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a blocked result");

endmodule

FILE: sim/pwl_drag_area_lookup_checker.sv
`timescale 1ns / 100ps
// result checker for pwl_drag_area_lookup: tracks config writes and table loads,
// predicts each query word and compares it with the result channel; uses pwl_pkg
module pwl_drag_area_lookup_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic [1:0]                         in_func,
  input  logic [3:0]                         in_entry_index,
  input  logic [pwl_pkg::WORD_W-1:0]         in_entry_word,
  input  logic signed [pwl_pkg::YAW_W-1:0]   in_yaw_angle,
  input  logic [pwl_pkg::POWER_W-1:0]        in_rider_power,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic [pwl_pkg::WORD_W-1:0]         out_drag_area,
  input  logic                               out_out_of_saddle,
  input  logic [3:0]                         out_segment,
  input  logic                               out_clipped,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic                               pready,
  input  logic [pwl_pkg::APB_AW-1:0]         paddr,
  input  logic [pwl_pkg::APB_DW-1:0]         pwdata,
  output int                                 fail_count,
  output int                                 words_pending
);
  import pwl_pkg::*;

  localparam int DEPTH = DEFAULT_TABLE_DEPTH;

  typedef struct packed {
    logic [WORD_W-1:0] drag_area;
    logic              standing;
    logic [3:0]        segment;
    logic              clipped;
  } drag_word_t;

  logic               mode;
  logic [POWER_W-1:0] thresh;
  logic [WORD_W-1:0]  standing_area;
  logic [3:0]         bp_count;
  logic [WORD_W-1:0]  yaw_bp [DEPTH];
  logic [WORD_W-1:0]  area_val [DEPTH+1];
  drag_word_t         expected_words [$];

  function automatic drag_word_t lookup_drag(logic signed [YAW_W-1:0] yaw,
                                             logic [POWER_W-1:0] power);
    drag_word_t r;
    int n, s;
    longint v1, v2, y1, y2, span, acc;
    r = '0;
    if (power > thresh) begin
      r.drag_area = standing_area;
      r.standing  = 1'b1;
      return r;
    end
    n = (bp_count > DEPTH) ? DEPTH : int'(bp_count);
    for (s = 0; s < n; s++) begin
      if (longint'(yaw) < longint'(yaw_bp[s])) break;
    end
    if (s >= n) begin
      acc = longint'(area_val[n]);
    end else if (mode == MODE_STEP) begin
      acc = longint'(area_val[s]);
    end else begin
      v1 = longint'(area_val[s]);
      v2 = longint'(area_val[s+1]);
      y1 = (s > 0) ? longint'(yaw_bp[s-1]) : 0;
      y2 = longint'(yaw_bp[s]);
      span = y2 - y1;
      // signed blend, quotient truncated toward zero
      acc = (span == 0) ? v1 : v1 + ((v2 - v1) * (longint'(yaw) - y1)) / span;
      if (acc < 0) begin
        acc = 0;
        r.clipped = 1'b1;
      end else if (acc > 65535) begin
        acc = 65535;
        r.clipped = 1'b1;
      end
    end
    r.drag_area = acc[WORD_W-1:0];
    r.segment   = s[3:0];
    return r;
  endfunction

  always @(posedge clk) begin
    drag_word_t exp_w;
    int errs;
    errs = 0;
    if (!rst_n) begin
      mode          <= MODE_INTERP;
      thresh        <= THRESH_RESET;
      standing_area <= '0;
      bp_count      <= '0;
      expected_words.delete();
      fail_count    <= 0;
      words_pending <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[3:2]))
          REG_MODE:     mode          <= pwdata[0];
          REG_THRESH:   thresh        <= pwdata[POWER_W-1:0];
          REG_STANDING: standing_area <= pwdata[WORD_W-1:0];
          REG_COUNT:    bp_count      <= pwdata[3:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $error("unexpected result word, drag_area %0d", out_drag_area);
          errs++;
        end else begin
          exp_w = expected_words.pop_front();
          if (out_drag_area !== exp_w.drag_area) begin
            $error("drag_area expected %0d actual %0d", exp_w.drag_area, out_drag_area);
            errs++;
          end
          if (out_out_of_saddle !== exp_w.standing) begin
            $error("out_of_saddle expected %0d actual %0d", exp_w.standing,
                   out_out_of_saddle);
            errs++;
          end
          if (out_segment !== exp_w.segment) begin
            $error("segment expected %0d actual %0d", exp_w.segment, out_segment);
            errs++;
          end
          if (out_clipped !== exp_w.clipped) begin
            $error("clipped expected %0d actual %0d", exp_w.clipped, out_clipped);
            errs++;
          end
        end
      end
      if (in_valid && in_ready) begin
        case (func_t'(in_func))
          FUNC_QUERY:  expected_words.push_back(lookup_drag(in_yaw_angle, in_rider_power));
          FUNC_WR_BP:  if (in_entry_index < DEPTH) yaw_bp[in_entry_index] = in_entry_word;
          FUNC_WR_VAL: if (in_entry_index <= DEPTH) area_val[in_entry_index] = in_entry_word;
          default: ;
        endcase
      end
      fail_count    <= fail_count + errs;
      words_pending <= expected_words.size();
    end
  end

endmodule

FILE: sim/pwl_drag_area_lookup_tb.sv
`timescale 1ns / 100ps
// testbench top for pwl_drag_area_lookup: clock, reset, apb setup, word stimulus
// and verdict; depends on pwl_pkg and pwl_drag_area_lookup_checker
module pwl_drag_area_lookup_tb;
  import pwl_pkg::*;

  localparam int DEPTH      = DEFAULT_TABLE_DEPTH;
  localparam int CYCLE_CAP  = 600000;
  localparam int DRAIN_WAIT = 60;
  localparam int LONG_HOLD  = 300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [1:0]                in_func = FUNC_NONE;
  logic [3:0]                in_entry_index = '0;
  logic [WORD_W-1:0]         in_entry_word = '0;
  logic signed [YAW_W-1:0]   in_yaw_angle = '0;
  logic [POWER_W-1:0]        in_rider_power = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [WORD_W-1:0]         out_drag_area;
  logic                      out_out_of_saddle;
  logic [3:0]                out_segment;
  logic                      out_clipped;
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [APB_AW-1:0]         paddr = '0;
  logic [APB_DW-1:0]         pwdata = '0;
  logic [APB_DW-1:0]         prdata;
  logic                      pready;

  int fail_count;
  int words_pending;
  int send_idle_pct;
  int recv_idle_pct;
  int cycle_count = 0;
  bit hold_request = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;
  logic word_taken = 1'b0;
  logic [WORD_W-1:0] bp_copy [DEPTH];   // tb side copy of breakpoints, for yaw aiming

  always #5 clk = ~clk;

  pwl_drag_area_lookup dut (.*);

  pwl_drag_area_lookup_checker checker_i (
    .clk, .rst_n, .in_valid, .in_ready, .in_func, .in_entry_index, .in_entry_word,
    .in_yaw_angle, .in_rider_power, .out_valid, .out_ready, .out_drag_area,
    .out_out_of_saddle, .out_segment, .out_clipped, .psel, .penable, .pwrite,
    .pready, .paddr, .pwdata, .fail_count, .words_pending
  );

  // handshake seen at the rising edge, acted on at the next falling edge
  always @(posedge clk) begin
    word_taken <= rst_n && in_valid && in_ready;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("pwl_drag_area_lookup verification failed");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off when asked
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_request && !hold_done) begin
      out_ready <= 1'b0;
      hold_left <= LONG_HOLD;
      hold_done <= 1'b1;
    end else begin
      out_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // apb write: setup cycle then access cycle; called at a falling edge
  task automatic reg_write(reg_idx_t idx, logic [APB_DW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'(idx) << 2;
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_regs(logic m, logic [11:0] th, logic [15:0] sa, logic [3:0] cnt);
    reg_write(REG_MODE, APB_DW'(m));
    reg_write(REG_THRESH, APB_DW'(th));
    reg_write(REG_STANDING, APB_DW'(sa));
    reg_write(REG_COUNT, APB_DW'(cnt));
  endtask

  // offer one word and hold it until taken; valid stays high between back-to-back words
  task automatic send_word(func_t f, logic [3:0] idx, logic [15:0] w,
                           logic signed [YAW_W-1:0] yaw, logic [11:0] pw);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_func        <= f;
    in_entry_index <= idx;
    in_entry_word  <= w;
    in_yaw_angle   <= yaw;
    in_rider_power <= pw;
    if (f == FUNC_WR_BP && idx < DEPTH) bp_copy[idx] = w;
    do @(negedge clk); while (!word_taken);
  endtask

  task automatic query(int yaw, int pw);
    send_word(FUNC_QUERY, 4'($urandom), 16'($urandom), YAW_W'(yaw), 12'(pw));
  endtask

  // non-decreasing breakpoints with random content, then all values
  task automatic load_table();
    int y;
    y = $urandom_range(4000);
    for (int k = 0; k < DEPTH; k++) begin
      send_word(FUNC_WR_BP, 4'(k), 16'(y), YAW_W'($urandom), 12'($urandom));
      y = y + (($urandom_range(9) == 0) ? 0 : $urandom_range(7000));
      if (y > 65535) y = 65535;
    end
    for (int k = 0; k <= DEPTH; k++) begin
      send_word(FUNC_WR_VAL, 4'(k), 16'($urandom), YAW_W'($urandom), 12'($urandom));
    end
  endtask

  task automatic random_words(int n_words);
    int pick, yaw;
    for (int i = 0; i < n_words; i++) begin
      pick = $urandom_range(99);
      if (pick < 65) begin
        // aim at a breakpoint edge half the time, else full yaw range
        if ($urandom_range(1)) yaw = int'(bp_copy[$urandom_range(DEPTH-1)])
                                     + $urandom_range(4) - 2;
        else yaw = $urandom_range(92160) - 46080;
        if (yaw > 46080) yaw = 46080;
        query(yaw, $urandom_range(4095));
      end else if (pick < 77) begin
        send_word(FUNC_WR_BP, 4'($urandom_range(8)), 16'($urandom), YAW_W'($urandom),
                  12'($urandom));
      end else if (pick < 89) begin
        send_word(FUNC_WR_VAL, 4'($urandom_range(15)), 16'($urandom), YAW_W'($urandom),
                  12'($urandom));
      end else if (pick < 93) begin
        send_word(FUNC_NONE, 4'($urandom), 16'($urandom), YAW_W'($urandom),
                  12'($urandom));
      end else begin
        load_table();
      end
    end
  endtask

  // let every expected word arrive, then the pipeline empty out
  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (words_pending != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  initial begin
    send_idle_pct = 14;
    recv_idle_pct = 77;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: full table first so no query reads an unwritten entry
    set_regs(MODE_INTERP, 12'd2000, 16'hFFFF, 4'd8);
    load_table();
    for (int k = 0; k < DEPTH; k++) begin
      query(int'(bp_copy[k]), 0);
      query(int'(bp_copy[k]) - 1, 0);
    end
    query(-46080, 0);
    query(46080, 4095);            // standing
    query(0, 2000);                // power at threshold, not standing
    query(0, 2001);                // just above threshold
    send_word(FUNC_WR_BP, 4'd1, bp_copy[0], '0, '0);   // zero span
    query(int'(bp_copy[0]), 0);
    send_word(FUNC_WR_BP, 4'd8, 16'hFFFF, '0, '0);     // out of range, ignored
    send_word(FUNC_WR_VAL, 4'd15, 16'hFFFF, '0, '0);   // out of range, ignored
    send_word(FUNC_NONE, 4'hF, 16'hFFFF, -17'sd1, 12'hFFF);
    // steep falling segment to force saturation at the top end
    send_word(FUNC_WR_VAL, 4'd0, 16'hFFFF, '0, '0);
    send_word(FUNC_WR_VAL, 4'd1, 16'h0000, '0, '0);
    query(-46080, 0);
    query(int'(bp_copy[0]) - 1, 0);

    // long receiver hold while the sender keeps pushing
    hold_request = 1'b1;
    random_words(145);
    settle();
    set_regs(MODE_STEP, 12'd0, 16'd0, 4'd0);
    random_words(145);
    settle();

    send_idle_pct = 77;
    recv_idle_pct = 14;
    set_regs(MODE_INTERP, 12'd4095, 16'd40000, 4'd15);
    random_words(145);
    settle();
    set_regs(MODE_STEP, 12'($urandom_range(4095)), 16'($urandom), 4'd3);
    random_words(145);
    settle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_regs(MODE_INTERP, 12'd3000, 16'($urandom), 4'd5);
    random_words(145);
    settle();
    set_regs(1'($urandom), 12'($urandom), 16'($urandom), 4'($urandom_range(8)));
    random_words(145);
    settle();

    if (fail_count == 0) begin
      $display("pwl_drag_area_lookup verification clean");
    end else begin
      $display("pwl_drag_area_lookup verification failed");
    end
    $finish;
  end

endmodule
